>>> src/cpet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// cpet_pkg
// Shared widths, codes, pipeline stage records and fixed-point helpers for the
// collision pair event tracker.
//------------------------------------------------------------------------------
package cpet_pkg;

    localparam int ID_BITS_DEF = 5;
    localparam int POS_W       = 24;
    localparam int SIZE_W      = 16;
    // Working width for Q8 pixel values after centers and grown bounds are formed.
    localparam int PW          = 28;
    // Squared distances stay below 2^50, so this width holds them with margin.
    localparam int SQ_W        = 2 * PW - 2;

    localparam logic [1:0] SHAPE_RECT   = 2'd0;
    localparam logic [1:0] SHAPE_CIRCLE = 2'd1;

    localparam logic signed [PW-1:0] PX_ONE = PW'(256);

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_RR,
        MODE_CC,
        MODE_CR
    } mode_t;

    typedef enum logic [1:0] {
        EVT_NONE,
        EVT_ENTER,
        EVT_STAY,
        EVT_EXIT
    } evt_t;

    typedef struct packed {
        logic [1:0]               shape1;
        logic signed [POS_W-1:0]  x1;
        logic signed [POS_W-1:0]  y1;
        logic [SIZE_W-1:0]        w1;
        logic [SIZE_W-1:0]        h1;
        logic [1:0]               shape2;
        logic signed [POS_W-1:0]  x2;
        logic signed [POS_W-1:0]  y2;
        logic [SIZE_W-1:0]        w2;
        logic [SIZE_W-1:0]        h2;
    } geom_t;

    typedef struct packed {
        mode_t                 mode;
        logic signed [PW-1:0]  rr_dx;
        logic signed [PW-1:0]  rr_dy;
        logic signed [PW-1:0]  rr_sw;
        logic signed [PW-1:0]  rr_sh;
        logic signed [PW-1:0]  c_x;
        logic signed [PW-1:0]  c_y;
        logic signed [PW-1:0]  c_r;
        logic signed [PW-1:0]  o_x;
        logic signed [PW-1:0]  o_y;
        logic signed [PW-1:0]  o_r;
        logic signed [PW-1:0]  r_lx;
        logic signed [PW-1:0]  r_ty;
        logic signed [PW-1:0]  r_hx;
        logic signed [PW-1:0]  r_by;
    } prep_t;

    typedef struct packed {
        mode_t            mode;
        logic             rr_hit;
        logic             span;
        logic             grown_in;
        logic [SQ_W-1:0]  q_xl;
        logic [SQ_W-1:0]  q_yt;
        logic [SQ_W-1:0]  q_r;
        logic [SQ_W-1:0]  q_xh;
        logic [SQ_W-1:0]  q_yb;
    } sq_t;

    // Half a size in Q8 pixels: size * 50, built from shifts.
    function automatic logic signed [PW-1:0] times50(input logic [SIZE_W-1:0] v);
        logic [PW-1:0] z;
        z = {{(PW - SIZE_W){1'b0}}, v};
        return $signed((z << 5) + (z << 4) + (z << 1));
    endfunction

    function automatic logic signed [PW-1:0] times100(input logic [SIZE_W-1:0] v);
        logic signed [PW-1:0] h;
        h = times50(v);
        return h <<< 1;
    endfunction

    function automatic logic signed [PW-1:0] sext_pos(input logic signed [POS_W-1:0] v);
        return {{(PW - POS_W){v[POS_W-1]}}, v};
    endfunction

    // Truncate a Q8 value toward zero to whole pixels.
    function automatic logic signed [PW-1:0] trunc_px(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] m;
        m = {v[PW-1:8], 8'h00};
        if (v[PW-1] && (v[7:0] != 8'h00))
        begin
            m = m + PX_ONE;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

>>> src/cpet_prep.sv
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// cpet_prep
// First compute stage: classifies the shape pair, puts the circle first, and
// forms centers, radii, rectangle spans and rectangle-pair overlap terms.
//------------------------------------------------------------------------------
module cpet_prep (
    input  logic            clk,
    input  logic            en,
    input  cpet_pkg::geom_t geom,
    output cpet_pkg::prep_t prep_reg
);
    import cpet_pkg::*;

    prep_t                prep_next;
    logic                 swap;
    logic signed [PW-1:0] x1, y1, x2, y2;
    logic signed [PW-1:0] w1h, h1h, w2h, h2h;

    always_comb
    begin
        x1  = sext_pos(geom.x1);
        y1  = sext_pos(geom.y1);
        x2  = sext_pos(geom.x2);
        y2  = sext_pos(geom.y2);
        w1h = times50(geom.w1);
        h1h = times50(geom.h1);
        w2h = times50(geom.w2);
        h2h = times50(geom.h2);

        // A rectangle first and a circle second is swapped so the circle leads.
        swap = (geom.shape1 == SHAPE_RECT) && (geom.shape2 == SHAPE_CIRCLE);

        case ({geom.shape1, geom.shape2})
            {SHAPE_RECT, SHAPE_RECT}:     prep_next.mode = MODE_RR;
            {SHAPE_CIRCLE, SHAPE_CIRCLE}: prep_next.mode = MODE_CC;
            {SHAPE_CIRCLE, SHAPE_RECT},
            {SHAPE_RECT, SHAPE_CIRCLE}:   prep_next.mode = MODE_CR;
            default:                      prep_next.mode = MODE_NONE;
        endcase

        prep_next.rr_dx = x1 - x2;
        prep_next.rr_dy = y1 - y2;
        prep_next.rr_sw = w1h + w2h;
        prep_next.rr_sh = h1h + h2h;

        prep_next.c_x = swap ? (x2 + w2h) : (x1 + w1h);
        prep_next.c_y = swap ? (y2 + h2h) : (y1 + h1h);
        prep_next.c_r = swap ? w2h : w1h;

        prep_next.o_x = x2 + w2h;
        prep_next.o_y = y2 + h2h;
        prep_next.o_r = w2h;

        prep_next.r_lx = swap ? x1 : x2;
        prep_next.r_ty = swap ? y1 : y2;
        prep_next.r_hx = swap ? (x1 + times100(geom.w1)) : (x2 + times100(geom.w2));
        prep_next.r_by = swap ? (y1 + times100(geom.h1)) : (y2 + times100(geom.h2));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
        end
    end

endmodule
`default_nettype wire

>>> src/cpet_square.sv
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// cpet_square
// Second compute stage: squares the distance terms, evaluates the span and
// grown-rectangle tests, and finishes the rectangle-pair overlap test.
//------------------------------------------------------------------------------
module cpet_square (
    input  logic            clk,
    input  logic            en,
    input  cpet_pkg::prep_t prep,
    output cpet_pkg::sq_t   sq_reg
);
    import cpet_pkg::*;

    sq_t                    sq_next;
    logic                   cc;
    logic signed [PW-1:0]   dxl, dxh, dyt, dyb;
    logic signed [PW-1:0]   a_xl, a_yt, a_r;
    logic signed [2*PW-1:0] p_xl, p_yt, p_r, p_xh, p_yb;

    always_comb
    begin
        cc  = (prep.mode == MODE_CC);
        dxl = prep.c_x - prep.r_lx;
        dxh = prep.c_x - prep.r_hx;
        dyt = prep.c_y - prep.r_ty;
        dyb = prep.c_y - prep.r_by;

        // The circle pair reuses the first three squarers.
        a_xl = cc ? (prep.c_x - prep.o_x) : dxl;
        a_yt = cc ? (prep.c_y - prep.o_y) : dyt;
        a_r  = cc ? (prep.c_r + prep.o_r) : prep.c_r;

        p_xl = a_xl * a_xl;
        p_yt = a_yt * a_yt;
        p_r  = a_r * a_r;
        p_xh = dxh * dxh;
        p_yb = dyb * dyb;

        sq_next.mode = prep.mode;
        sq_next.q_xl = p_xl[SQ_W-1:0];
        sq_next.q_yt = p_yt[SQ_W-1:0];
        sq_next.q_r  = p_r[SQ_W-1:0];
        sq_next.q_xh = p_xh[SQ_W-1:0];
        sq_next.q_yb = p_yb[SQ_W-1:0];

        sq_next.span = ((prep.r_lx <= prep.c_x) && (prep.c_x <= prep.r_hx)) ||
                       ((prep.r_ty <= prep.c_y) && (prep.c_y <= prep.r_by));

        sq_next.grown_in = (trunc_px(prep.r_lx - prep.c_r) < prep.c_x) &&
                           (prep.c_x < trunc_px(prep.r_hx + prep.c_r)) &&
                           (trunc_px(prep.r_ty - prep.c_r) < prep.c_y) &&
                           (prep.c_y < trunc_px(prep.r_by + prep.c_r));

        sq_next.rr_hit = (prep.rr_dx < prep.rr_sw) && (-prep.rr_dx < prep.rr_sw) &&
                         (prep.rr_dy < prep.rr_sh) && (-prep.rr_dy < prep.rr_sh);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_next;
        end
    end

endmodule
`default_nettype wire

>>> src/cpet_decide.sv
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// cpet_decide
// Third compute stage: sums squared distances, compares them with the squared
// radius and selects the hit result for the shape pair.
//------------------------------------------------------------------------------
module cpet_decide (
    input  logic          clk,
    input  logic          en,
    input  cpet_pkg::sq_t sq,
    output logic          hit_reg
);
    import cpet_pkg::*;

    logic            hit_next;
    logic [SQ_W:0]   s_xl_yt, s_xh_yt, s_xl_yb, s_xh_yb, r2;
    logic            corner;

    always_comb
    begin
        s_xl_yt = {1'b0, sq.q_xl} + {1'b0, sq.q_yt};
        s_xh_yt = {1'b0, sq.q_xh} + {1'b0, sq.q_yt};
        s_xl_yb = {1'b0, sq.q_xl} + {1'b0, sq.q_yb};
        s_xh_yb = {1'b0, sq.q_xh} + {1'b0, sq.q_yb};
        r2      = {1'b0, sq.q_r};

        corner = (s_xl_yt <= r2) || (s_xh_yt <= r2) ||
                 (s_xl_yb <= r2) || (s_xh_yb <= r2);

        case (sq.mode)
            MODE_RR: hit_next = sq.rr_hit;
            MODE_CC: hit_next = (s_xl_yt <= r2);
            MODE_CR: hit_next = sq.span ? sq.grown_in : corner;
            default: hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
        end
    end

endmodule
`default_nettype wire

>>> src/cpet_track.sv
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// cpet_track
// Per-pair touching memory with its clearing pass after reset, and the event
// stage that turns the hit result and the stored bit into enter, stay or exit.
//------------------------------------------------------------------------------
module cpet_track #(
    parameter int ID_BITS = cpet_pkg::ID_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rd_en,
    input  logic [2*ID_BITS-1:0]   rd_idx,
    input  logic                   wr_en,
    input  logic [2*ID_BITS-1:0]   wr_idx,
    input  logic                   hit,
    output logic                   clearing,
    output cpet_pkg::evt_t         evt_reg,
    output logic                   hit_reg
);
    import cpet_pkg::*;

    localparam int IDX_W = 2 * ID_BITS;
    localparam int DEPTH = 1 << IDX_W;

    logic                 mem [DEPTH];
    logic                 touch_reg;
    logic [IDX_W:0]       clr_cnt_reg, clr_cnt_next;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic                 mem_wdata;
    evt_t                 evt_next;

    always_comb
    begin
        clearing     = !clr_cnt_reg[IDX_W];
        clr_cnt_next = clearing ? (clr_cnt_reg + 1'b1) : clr_cnt_reg;
        mem_we       = clearing || wr_en;
        mem_waddr    = clearing ? clr_cnt_reg[IDX_W-1:0] : wr_idx;
        mem_wdata    = clearing ? 1'b0 : hit;

        if (hit)
        begin
            evt_next = touch_reg ? EVT_STAY : EVT_ENTER;
        end
        else
        begin
            evt_next = touch_reg ? EVT_EXIT : EVT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // The item entering the event stage may write the entry that the next item
    // reads at the same edge; its new value is forwarded.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_idx == rd_idx))
            begin
                touch_reg <= hit;
            end
            else
            begin
                touch_reg <= mem[rd_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            evt_reg <= evt_next;
            hit_reg <= hit;
        end
    end

endmodule
`default_nettype wire

>>> src/collision_pair_event_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: a result beat is presented on the master side after its input beat is
// accepted and passes the input register, three compute stages and the result register.
// Throughput: one pair per clock; the stages stall only when the result is not taken.
// Reset: after rst_n is released a clearing pass zeroes the pair memory, one entry a
// cycle, over all 2^(2*ID_BITS) entries (1024 by default), during which s_tready stays low.
//------------------------------------------------------------------------------
// collision_pair_event_tracker
// Tests an ordered collider pair for intersection and reports enter, stay, exit
// or none against a touching bit kept for each ordered pair.
//------------------------------------------------------------------------------
module collision_pair_event_tracker #(
    parameter  int ID_BITS  = cpet_pkg::ID_BITS_DEF,
    localparam int DATA_W   = 2 * ID_BITS + 4 * cpet_pkg::POS_W + 4 * cpet_pkg::SIZE_W,
    localparam int TDATA_W  = ((DATA_W + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    // Input beats.
    input  logic               s_tvalid,
    output logic               s_tready,
    // From bit 0: first_id, second_id, first_x, first_y, first_w, first_h,
    // second_x, second_y, second_w, second_h, zero padding.
    input  logic [TDATA_W-1:0] s_tdata,
    // From bit 0: first_shape, second_shape.
    input  logic [3:0]         s_tuser,
    // Result beats.
    output logic               m_tvalid,
    input  logic               m_tready,
    // From bit 0: event_res, hit, zero padding.
    output logic [7:0]         m_tdata
);
    import cpet_pkg::*;

    localparam int IDX_W  = 2 * ID_BITS;
    localparam int OFF_X1 = IDX_W;
    localparam int OFF_Y1 = OFF_X1 + POS_W;
    localparam int OFF_W1 = OFF_Y1 + POS_W;
    localparam int OFF_H1 = OFF_W1 + SIZE_W;
    localparam int OFF_X2 = OFF_H1 + SIZE_W;
    localparam int OFF_Y2 = OFF_X2 + POS_W;
    localparam int OFF_W2 = OFF_Y2 + POS_W;
    localparam int OFF_H2 = OFF_W2 + SIZE_W;

    // Stage valid flags: s1 is the input register, s4 holds the hit result,
    // and the result register drives m_tvalid.
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, out_vld_reg;
    logic ld1, ld2, ld3, ld4, ld5;
    logic free1, free2, free3, free4, free5;
    logic clearing;

    geom_t            geom_in;
    geom_t            geom_reg;
    prep_t            prep_reg;
    sq_t              sq_reg;
    logic             hit4_reg;
    evt_t             evt_reg;
    logic             hit_out_reg;

    // The pair index travels beside the compute stages; it is the memory address.
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;

    // Each stage loads when the one before holds an item and it is empty or
    // is itself moving on. The chain is short, so it stays combinational.
    always_comb
    begin
        free5    = !out_vld_reg || m_tready;
        ld5      = s4_vld_reg && free5;
        free4    = !s4_vld_reg || ld5;
        ld4      = s3_vld_reg && free4;
        free3    = !s3_vld_reg || ld4;
        ld3      = s2_vld_reg && free3;
        free2    = !s2_vld_reg || ld3;
        ld2      = s1_vld_reg && free2;
        free1    = !s1_vld_reg || ld2;
        s_tready = free1 && !clearing;
        ld1      = s_tvalid && s_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= ld1 || (s1_vld_reg && !ld2);
            s2_vld_reg  <= ld2 || (s2_vld_reg && !ld3);
            s3_vld_reg  <= ld3 || (s3_vld_reg && !ld4);
            s4_vld_reg  <= ld4 || (s4_vld_reg && !ld5);
            out_vld_reg <= ld5 || (out_vld_reg && !m_tready);
        end
    end

    // Unpack the input beat into the geometry record.
    always_comb
    begin
        geom_in.shape1 = s_tuser[1:0];
        geom_in.shape2 = s_tuser[3:2];
        geom_in.x1     = s_tdata[OFF_X1 +: POS_W];
        geom_in.y1     = s_tdata[OFF_Y1 +: POS_W];
        geom_in.w1     = s_tdata[OFF_W1 +: SIZE_W];
        geom_in.h1     = s_tdata[OFF_H1 +: SIZE_W];
        geom_in.x2     = s_tdata[OFF_X2 +: POS_W];
        geom_in.y2     = s_tdata[OFF_Y2 +: POS_W];
        geom_in.w2     = s_tdata[OFF_W2 +: SIZE_W];
        geom_in.h2     = s_tdata[OFF_H2 +: SIZE_W];
    end

    // Input register and index pipeline. The index is second_id above first_id,
    // exactly the low 2*ID_BITS bits of the beat.
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            geom_reg <= geom_in;
            idx1_reg <= s_tdata[IDX_W-1:0];
        end
        if (ld2)
        begin
            idx2_reg <= idx1_reg;
        end
        if (ld3)
        begin
            idx3_reg <= idx2_reg;
        end
        if (ld4)
        begin
            idx4_reg <= idx3_reg;
        end
    end

    cpet_prep u_prep (
        .clk      (clk),
        .en       (ld2),
        .geom     (geom_reg),
        .prep_reg (prep_reg)
    );

    cpet_square u_square (
        .clk    (clk),
        .en     (ld3),
        .prep   (prep_reg),
        .sq_reg (sq_reg)
    );

    cpet_decide u_decide (
        .clk     (clk),
        .en      (ld4),
        .sq      (sq_reg),
        .hit_reg (hit4_reg)
    );

    // The touching bit is read as an item enters the hit stage, and written
    // back as it moves into the result register.
    cpet_track #(
        .ID_BITS (ID_BITS)
    ) u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (ld4),
        .rd_idx   (idx3_reg),
        .wr_en    (ld5),
        .wr_idx   (idx4_reg),
        .hit      (hit4_reg),
        .clearing (clearing),
        .evt_reg  (evt_reg),
        .hit_reg  (hit_out_reg)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b00000, hit_out_reg, evt_reg};

endmodule
`default_nettype wire
